FILE: design/cau_pkg.sv
// Shared constants for the complex arithmetic unit: command, status and selector codes.
// No dependencies; imported by every module of the block.
package cau_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int TOL_W          = 17;
	localparam int CMD_W          = 4;
	localparam int ST_W           = 2;

	localparam logic [TOL_W-1:0] TOL_RESET = 17'd7;

	localparam logic [CMD_W-1:0] CMD_ADD   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_SUB   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_MUL   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_DIV   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_CONJ  = 4'd4;
	localparam logic [CMD_W-1:0] CMD_NEG   = 4'd5;
	localparam logic [CMD_W-1:0] CMD_MAG   = 4'd6;
	localparam logic [CMD_W-1:0] CMD_MAGSQ = 4'd7;
	localparam logic [CMD_W-1:0] CMD_EQ    = 4'd8;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_SAT  = 2'd1;
	localparam logic [ST_W-1:0] ST_DIV0 = 2'd2;

	// which unit delivers the final result
	typedef enum logic [1:0] {
		SEL_SIDE,
		SEL_DIV,
		SEL_MAG
	} res_sel_t;

endpackage

FILE: design/cau_step.sv
// One iteration stage of the complex arithmetic unit: a restoring divide step for both
// quotient parts and, when DO_SQRT is set, one digit of the integer square root. Uses cau_pkg.
module cau_step #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter bit DO_SQRT    = 1'b1,
	parameter int SIDE_W     = 2 * cau_pkg::DATA_WIDTH_DEF + 9
) (
	input  logic                      clk,
	input  logic                      load,
	input  logic [2*DATA_WIDTH:0]     den_i,
	input  logic [2*DATA_WIDTH+1:0]   rem_re_i,
	input  logic [2*DATA_WIDTH+1:0]   rem_im_i,
	input  logic [DATA_WIDTH:0]       lo_re_i,
	input  logic [DATA_WIDTH:0]       lo_im_i,
	input  logic [DATA_WIDTH:0]       q_re_i,
	input  logic [DATA_WIDTH:0]       q_im_i,
	input  logic [2*DATA_WIDTH-1:0]   sq_i,
	input  logic [DATA_WIDTH+1:0]     srem_i,
	input  logic [DATA_WIDTH-1:0]     root_i,
	input  logic [SIDE_W-1:0]         side_i,
	output logic [2*DATA_WIDTH:0]     den_o,
	output logic [2*DATA_WIDTH+1:0]   rem_re_o,
	output logic [2*DATA_WIDTH+1:0]   rem_im_o,
	output logic [DATA_WIDTH:0]       lo_re_o,
	output logic [DATA_WIDTH:0]       lo_im_o,
	output logic [DATA_WIDTH:0]       q_re_o,
	output logic [DATA_WIDTH:0]       q_im_o,
	output logic [2*DATA_WIDTH-1:0]   sq_o,
	output logic [DATA_WIDTH+1:0]     srem_o,
	output logic [DATA_WIDTH-1:0]     root_o,
	output logic [SIDE_W-1:0]         side_o
);
	import cau_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int DB = 2 * W + 1;

	logic [DB:0] dden;
	logic [DB:0] r_re, r_im;
	logic        ge_re, ge_im;

	assign dden  = {1'b0, den_i};
	assign r_re  = {rem_re_i[DB-1:0], lo_re_i[W]};
	assign r_im  = {rem_im_i[DB-1:0], lo_im_i[W]};
	assign ge_re = r_re >= dden;
	assign ge_im = r_im >= dden;

	always_ff @(posedge clk) begin
		if (load) begin
			den_o    <= den_i;
			rem_re_o <= ge_re ? r_re - dden : r_re;
			rem_im_o <= ge_im ? r_im - dden : r_im;
			lo_re_o  <= {lo_re_i[W-1:0], 1'b0};
			lo_im_o  <= {lo_im_i[W-1:0], 1'b0};
			q_re_o   <= {q_re_i[W-1:0], ge_re};
			q_im_o   <= {q_im_i[W-1:0], ge_im};
			side_o   <= side_i;
		end
	end

	generate
		if (DO_SQRT) begin : g_sqrt
			logic [W+1:0] r2, trial;
			logic         g;

			assign r2    = {srem_i[W-1:0], sq_i[2*W-1 -: 2]};
			assign trial = {root_i, 2'b01};
			assign g     = r2 >= trial;

			always_ff @(posedge clk) begin
				if (load) begin
					srem_o <= g ? r2 - trial : r2;
					root_o <= {root_i[W-2:0], g};
					sq_o   <= {sq_i[2*W-3:0], 2'b00};
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (load) begin
					srem_o <= srem_i;
					root_o <= root_i;
					sq_o   <= sq_i;
				end
			end
		end
	endgenerate

endmodule

FILE: design/complex_arithmetic_unit_top.sv
// Top level of the complex arithmetic unit: front stages, iteration chain, output skid.
// Uses cau_pkg and cau_step.
//
// Usage:
//  s_axis carries one item per transfer: tuser holds the command, tdata the four operands
//  in signed fixed point. m_axis returns one result per item in the same order: tdata
//  holds the real and imaginary parts, tuser the equality flag and the status code.
//  cfg_valid/cfg_data write the equality tolerance; cfg_ready is always high, and the
//  register should only be written while no item is in flight.
//  Every item takes the same path: operand register, multipliers, sums, magnitudes,
//  divider set-up, then DATA_WIDTH+1 divide steps (the square root runs alongside, two
//  bits a step), and last the output register that drives m_axis.
//  One item is accepted every cycle while s_axis_tready is high.
//  The chain of divide steps makes up most of the pipeline; each stage holds one item.
//  Reset clears all valid bits and sets the tolerance to its reset value.
//  When m_axis stalls, one further result goes into a skid register; only after that
//  the whole pipeline holds and s_axis_tready falls. Nothing is lost or repeated.
module complex_arithmetic_unit_top #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// a_re, a_im, b_re, b_im from bit 0 up, zero padded to bytes
	input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	// cmd
	input  logic [cau_pkg::CMD_W-1:0]             s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// res_re, res_im from bit 0 up, zero padded to bytes
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
	// is_equal, status from bit 0 up
	output logic [cau_pkg::ST_W:0]                m_axis_tuser,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cau_pkg::TOL_W-1:0]             cfg_data
);
	import cau_pkg::*;

	localparam int W      = DATA_WIDTH;
	localparam int F      = FRAC_BITS;
	localparam int PW     = 2 * W;
	localparam int DB     = 2 * W + 1;
	localparam int NB     = DB + F;
	localparam int HW     = W + F;
	localparam int CW     = (HW > DB) ? HW : DB;
	localparam int SW     = 2 * W + 9;
	localparam int NS     = W + 6;
	localparam int OUT_DW = ((2 * W + 7) / 8) * 8;

	localparam logic [W-1:0]  SMAX   = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  SMIN   = {1'b1, {(W-1){1'b0}}};
	localparam logic [DB-1:0] NMAG_D = DB'(1) << (W - 1);
	localparam logic [DB-1:0] SMAX_D = NMAG_D - DB'(1);

	// returns {saturated, value} of a sign and magnitude pair
	function automatic logic [W:0] clamp_sm(input logic neg, input logic [DB-1:0] m);
		logic [W-1:0] v;
		logic [W:0]   r;
		v = m[W-1:0];
		if (!neg || m == '0) begin
			if (m > SMAX_D) r = {1'b1, SMAX};
			else r = {1'b0, v};
		end else begin
			if (m > NMAG_D) r = {1'b1, SMIN};
			else r = {1'b0, -v};
		end
		return r;
	endfunction

	logic [TOL_W-1:0] tol_q;
	logic [NS-1:0]    vld_q;
	logic             en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	// ---------------- stage 1: operands
	logic [CMD_W-1:0]    cmd_s1;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= s_axis_tuser;
			ar_s1  <= s_axis_tdata[W-1:0];
			ai_s1  <= s_axis_tdata[2*W-1:W];
			br_s1  <= s_axis_tdata[3*W-1:2*W];
			bi_s1  <= s_axis_tdata[4*W-1:3*W];
		end
	end

	// ---------------- stage 2: products, simple operations
	logic signed [W-1:0] mb0, mb1;
	logic signed [W:0]   ear, eai, ebr, ebi, t_re, t_im, dr, di;
	logic [W:0]          adr, adi, tol_x;
	logic                s_eq;

	assign mb0   = (cmd_s1 == CMD_MAG || cmd_s1 == CMD_MAGSQ) ? ar_s1 : br_s1;
	assign mb1   = (cmd_s1 == CMD_MAG || cmd_s1 == CMD_MAGSQ) ? ai_s1 : bi_s1;
	assign ear   = (W+1)'(ar_s1);
	assign eai   = (W+1)'(ai_s1);
	assign ebr   = (W+1)'(br_s1);
	assign ebi   = (W+1)'(bi_s1);
	assign dr    = ear - ebr;
	assign di    = eai - ebi;
	assign adr   = dr[W] ? (W+1)'(-dr) : (W+1)'(dr);
	assign adi   = di[W] ? (W+1)'(-di) : (W+1)'(di);
	assign tol_x = (W+1)'(tol_q);
	assign s_eq  = (cmd_s1 == CMD_EQ) && (adr < tol_x) && (adi < tol_x);

	always_comb begin
		t_re = '0;
		t_im = '0;
		case (cmd_s1)
			CMD_ADD: begin
				t_re = ear + ebr;
				t_im = eai + ebi;
			end
			CMD_SUB: begin
				t_re = ear - ebr;
				t_im = eai - ebi;
			end
			CMD_CONJ: begin
				t_re = ear;
				t_im = -eai;
			end
			CMD_NEG: begin
				t_re = -ear;
				t_im = -eai;
			end
			default: begin
				t_re = '0;
				t_im = '0;
			end
		endcase
	end

	logic [CMD_W-1:0]     cmd_s2;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic [W-1:0]         sre_s2, sim_s2;
	logic                 seq_s2, ssat_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2  <= cmd_s1;
			p0_s2   <= ar_s1 * mb0;
			p1_s2   <= ai_s1 * mb1;
			p2_s2   <= ai_s1 * br_s1;
			p3_s2   <= ar_s1 * bi_s1;
			p4_s2   <= br_s1 * br_s1;
			p5_s2   <= bi_s1 * bi_s1;
			sre_s2  <= (t_re[W] != t_re[W-1]) ? (t_re[W] ? SMIN : SMAX) : t_re[W-1:0];
			sim_s2  <= (t_im[W] != t_im[W-1]) ? (t_im[W] ? SMIN : SMAX) : t_im[W-1:0];
			seq_s2  <= s_eq;
			ssat_s2 <= (t_re[W] != t_re[W-1]) || (t_im[W] != t_im[W-1]);
		end
	end

	// ---------------- stage 3: sums of products
	logic [CMD_W-1:0]     cmd_s3;
	logic signed [DB-1:0] sr_s3, si_s3;
	logic [DB-1:0]        den_s3;
	logic [W-1:0]         sre_s3, sim_s3;
	logic                 seq_s3, ssat_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3  <= cmd_s2;
			sr_s3   <= (cmd_s2 == CMD_MUL) ? DB'(p0_s2) - DB'(p1_s2) : DB'(p0_s2) + DB'(p1_s2);
			si_s3   <= (cmd_s2 == CMD_MUL) ? DB'(p2_s2) + DB'(p3_s2) : DB'(p2_s2) - DB'(p3_s2);
			den_s3  <= DB'($unsigned(p4_s2)) + DB'($unsigned(p5_s2));
			sre_s3  <= sre_s2;
			sim_s3  <= sim_s2;
			seq_s3  <= seq_s2;
			ssat_s3 <= ssat_s2;
		end
	end

	// ---------------- stage 4: magnitudes
	logic [CMD_W-1:0] cmd_s4;
	logic [DB-1:0]    mre_s4, mim_s4, den_s4;
	logic             nre_s4, nim_s4, dz_s4;
	logic [W-1:0]     sre_s4, sim_s4;
	logic             seq_s4, ssat_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s4  <= cmd_s3;
			mre_s4  <= sr_s3[DB-1] ? DB'(-sr_s3) : DB'(sr_s3);
			mim_s4  <= si_s3[DB-1] ? DB'(-si_s3) : DB'(si_s3);
			nre_s4  <= sr_s3[DB-1];
			nim_s4  <= si_s3[DB-1];
			den_s4  <= den_s3;
			dz_s4   <= den_s3 == '0;
			sre_s4  <= sre_s3;
			sim_s4  <= sim_s3;
			seq_s4  <= seq_s3;
			ssat_s4 <= ssat_s3;
		end
	end

	// ---------------- stage 5: divider set-up, scaled results
	logic [NB-1:0] x_re, x_im;
	logic [HW-1:0] hi_re, hi_im;
	logic          ovf_re, ovf_im;
	logic [W:0]    c_re, c_im;
	logic [W-1:0]  n_re, n_im;
	logic          n_eq;
	logic [ST_W-1:0] n_st;
	res_sel_t      n_sel;

	assign x_re   = {mre_s4, {F{1'b0}}};
	assign x_im   = {mim_s4, {F{1'b0}}};
	assign hi_re  = x_re[NB-1 -: HW];
	assign hi_im  = x_im[NB-1 -: HW];
	assign ovf_re = CW'(hi_re) >= CW'(den_s4);
	assign ovf_im = CW'(hi_im) >= CW'(den_s4);
	assign c_re   = clamp_sm(nre_s4 && cmd_s4 == CMD_MUL, mre_s4 >> F);
	assign c_im   = clamp_sm(nim_s4, mim_s4 >> F);

	always_comb begin
		n_re  = sre_s4;
		n_im  = sim_s4;
		n_eq  = seq_s4;
		n_st  = ssat_s4 ? ST_SAT : ST_OK;
		n_sel = SEL_SIDE;
		case (cmd_s4)
			CMD_MUL: begin
				n_re = c_re[W-1:0];
				n_im = c_im[W-1:0];
				n_st = (c_re[W] || c_im[W]) ? ST_SAT : ST_OK;
			end
			CMD_MAGSQ: begin
				n_re = c_re[W-1:0];
				n_im = '0;
				n_st = c_re[W] ? ST_SAT : ST_OK;
			end
			CMD_DIV: begin
				n_re  = '0;
				n_im  = '0;
				n_st  = dz_s4 ? ST_DIV0 : ST_OK;
				n_sel = dz_s4 ? SEL_SIDE : SEL_DIV;
			end
			CMD_MAG: begin
				n_re  = '0;
				n_im  = '0;
				n_st  = ST_OK;
				n_sel = SEL_MAG;
			end
			default: begin
				n_sel = SEL_SIDE;
			end
		endcase
	end

	logic [DB-1:0] den_s5;
	logic [DB:0]   rre_s5, rim_s5;
	logic [W:0]    lre_s5, lim_s5;
	logic [PW-1:0] sq_s5;
	logic [SW-1:0] side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s5  <= den_s4;
			rre_s5  <= (DB+1)'(hi_re);
			rim_s5  <= (DB+1)'(hi_im);
			lre_s5  <= x_re[W:0];
			lim_s5  <= x_im[W:0];
			sq_s5   <= mre_s4[PW-1:0];
			side_s5 <= {ovf_im, ovf_re, nim_s4, nre_s4, n_sel, n_st, n_eq, n_im, n_re};
		end
	end

	// ---------------- iteration chain
	logic [DB-1:0] den_c  [0:W+1];
	logic [DB:0]   rre_c  [0:W+1];
	logic [DB:0]   rim_c  [0:W+1];
	logic [W:0]    lre_c  [0:W+1];
	logic [W:0]    lim_c  [0:W+1];
	logic [W:0]    qre_c  [0:W+1];
	logic [W:0]    qim_c  [0:W+1];
	logic [PW-1:0] sq_c   [0:W+1];
	logic [W+1:0]  srem_c [0:W+1];
	logic [W-1:0]  root_c [0:W+1];
	logic [SW-1:0] side_c [0:W+1];

	assign den_c[0]  = den_s5;
	assign rre_c[0]  = rre_s5;
	assign rim_c[0]  = rim_s5;
	assign lre_c[0]  = lre_s5;
	assign lim_c[0]  = lim_s5;
	assign qre_c[0]  = '0;
	assign qim_c[0]  = '0;
	assign sq_c[0]   = sq_s5;
	assign srem_c[0] = '0;
	assign root_c[0] = '0;
	assign side_c[0] = side_s5;

	generate
		for (genvar k = 0; k <= W; k++) begin : g_step
			cau_step #(
				.DATA_WIDTH (W),
				.DO_SQRT    ((k < W) ? 1'b1 : 1'b0),
				.SIDE_W     (SW)
			) u_step (
				.clk      (clk),
				.load     (en),
				.den_i    (den_c[k]),
				.rem_re_i (rre_c[k]),
				.rem_im_i (rim_c[k]),
				.lo_re_i  (lre_c[k]),
				.lo_im_i  (lim_c[k]),
				.q_re_i   (qre_c[k]),
				.q_im_i   (qim_c[k]),
				.sq_i     (sq_c[k]),
				.srem_i   (srem_c[k]),
				.root_i   (root_c[k]),
				.side_i   (side_c[k]),
				.den_o    (den_c[k+1]),
				.rem_re_o (rre_c[k+1]),
				.rem_im_o (rim_c[k+1]),
				.lo_re_o  (lre_c[k+1]),
				.lo_im_o  (lim_c[k+1]),
				.q_re_o   (qre_c[k+1]),
				.q_im_o   (qim_c[k+1]),
				.sq_o     (sq_c[k+1]),
				.srem_o   (srem_c[k+1]),
				.root_o   (root_c[k+1]),
				.side_o   (side_c[k+1])
			);
		end
	endgenerate

	// ---------------- result selection
	logic [SW-1:0]   fs;
	logic [W-1:0]    f_re, f_im;
	logic            f_eq;
	logic [ST_W-1:0] f_st;
	logic [W:0]      d_re, d_im, m_rt;
	res_sel_t        f_sel;

	assign fs    = side_c[W+1];
	assign f_sel = res_sel_t'(fs[2*W+4:2*W+3]);
	assign d_re  = clamp_sm(fs[2*W+5], fs[2*W+7] ? NMAG_D + DB'(1) : DB'(qre_c[W+1]));
	assign d_im  = clamp_sm(fs[2*W+6], fs[2*W+8] ? NMAG_D + DB'(1) : DB'(qim_c[W+1]));
	assign m_rt  = clamp_sm(1'b0, DB'(root_c[W+1]));

	always_comb begin
		f_re = fs[W-1:0];
		f_im = fs[2*W-1:W];
		f_eq = fs[2*W];
		f_st = fs[2*W+2:2*W+1];
		case (f_sel)
			SEL_DIV: begin
				f_re = d_re[W-1:0];
				f_im = d_im[W-1:0];
				f_st = (d_re[W] || d_im[W]) ? ST_SAT : ST_OK;
			end
			SEL_MAG: begin
				f_re = m_rt[W-1:0];
				f_im = '0;
				f_st = m_rt[W] ? ST_SAT : ST_OK;
			end
			default: begin
				f_re = fs[W-1:0];
			end
		endcase
	end

	// ---------------- valid chain, output register and skid
	logic            m_v_q, sk_v_q;
	logic [W-1:0]    m_re_q, m_im_q, sk_re_q, sk_im_q;
	logic            m_eq_q, sk_eq_q;
	logic [ST_W-1:0] m_st_q, sk_st_q;
	logic            push;

	assign en            = !sk_v_q;
	assign s_axis_tready = en;
	assign push          = en && vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			m_v_q  <= 1'b0;
			sk_v_q <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[NS-2:0], s_axis_tvalid};
			end
			if (!m_v_q || m_axis_tready) begin
				if (sk_v_q) begin
					m_v_q  <= 1'b1;
					sk_v_q <= 1'b0;
				end else begin
					m_v_q <= push;
				end
			end else if (push) begin
				sk_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!m_v_q || m_axis_tready) begin
			if (sk_v_q) begin
				m_re_q <= sk_re_q;
				m_im_q <= sk_im_q;
				m_eq_q <= sk_eq_q;
				m_st_q <= sk_st_q;
			end else begin
				m_re_q <= f_re;
				m_im_q <= f_im;
				m_eq_q <= f_eq;
				m_st_q <= f_st;
			end
		end else if (push) begin
			sk_re_q <= f_re;
			sk_im_q <= f_im;
			sk_eq_q <= f_eq;
			sk_st_q <= f_st;
		end
	end

	assign m_axis_tvalid = m_v_q;
	assign m_axis_tdata  = OUT_DW'({m_im_q, m_re_q});
	assign m_axis_tuser  = {m_st_q, m_eq_q};

endmodule

FILE: design/cau_checker.sv
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Uses cau_pkg; attached to complex_arithmetic_unit_top by the bind below.
module cau_checker #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	input logic [cau_pkg::ST_W:0]            m_axis_tuser
);
	import cau_pkg::*;

	localparam int W = DATA_WIDTH;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[ST_W:1] == ST_OK || m_axis_tuser[ST_W:1] == ST_SAT ||
			m_axis_tuser[ST_W:1] == ST_DIV0))
		else $error("undefined status code");

	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[ST_W:1] == ST_DIV0 |-> m_axis_tdata[2*W-1:0] == '0)
		else $error("divide by zero result not zero");

	a_equal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			m_axis_tuser[ST_W:1] == ST_OK && m_axis_tdata[2*W-1:0] == '0)
		else $error("equality result with data or status");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind complex_arithmetic_unit_top cau_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_cau_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/cau_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the complex arithmetic unit: watches s_axis, m_axis and cfg, predicts each
// result in order and compares it field by field. Uses cau_pkg; no other dependencies.
module cau_scoreboard (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,
	input  logic [3:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [63:0]  m_axis_tdata,
	input  logic [2:0]   m_axis_tuser,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [16:0]  cfg_data,
	output int           errors,
	output int           pending
);
	import cau_pkg::*;

	typedef struct {
		bit          neg;
		bit [63:0]   mag;
	} smag_t;

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic        eq;
		logic [1:0]  st;
	} cplx_res_t;

	localparam bit [63:0] NEG_LIM = 64'h8000_0000;
	localparam bit [63:0] POS_LIM = 64'h7FFF_FFFF;

	cplx_res_t       expected_results[$];
	logic [16:0]     tolerance;
	bit              clipped;

	function automatic bit [63:0] abs64(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic smag_t sm_of(longint v);
		smag_t r;
		r.neg = v < 0;
		r.mag = abs64(v);
		return r;
	endfunction

	function automatic smag_t sm_mul(longint a, longint b);
		smag_t r;
		r.mag = abs64(a) * abs64(b);
		r.neg = ((a < 0) != (b < 0)) && r.mag != 0;
		return r;
	endfunction

	function automatic smag_t sm_neg(smag_t x);
		if (x.mag != 0)
			x.neg = !x.neg;
		return x;
	endfunction

	function automatic smag_t sm_add(smag_t x, smag_t y);
		smag_t r;
		if (x.neg == y.neg) begin
			r.neg = x.neg;
			r.mag = x.mag + y.mag;
		end else if (x.mag >= y.mag) begin
			r.neg = x.neg;
			r.mag = x.mag - y.mag;
		end else begin
			r.neg = y.neg;
			r.mag = y.mag - x.mag;
		end
		if (r.mag == 0)
			r.neg = 0;
		return r;
	endfunction

	function automatic longint clip(smag_t x);
		if (!x.neg) begin
			if (x.mag > POS_LIM) begin
				clipped = 1;
				return longint'(POS_LIM);
			end
			return longint'(x.mag);
		end
		if (x.mag > NEG_LIM) begin
			clipped = 1;
			return -longint'(NEG_LIM);
		end
		return -longint'(x.mag);
	endfunction

	function automatic longint drop_frac(smag_t x);
		x.mag = x.mag >> FRAC_BITS_DEF;
		if (x.mag == 0)
			x.neg = 0;
		return clip(x);
	endfunction

	// long division carried FRAC_BITS further, stopping once the quotient is out of range
	function automatic longint frac_div(smag_t n, bit [63:0] den);
		bit [63:0] q;
		bit [63:0] r;
		smag_t     res;
		bit        over;
		q = n.mag / den;
		r = n.mag % den;
		over = q > NEG_LIM;
		for (int i = 0; i < FRAC_BITS_DEF && !over; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
			over = q > NEG_LIM;
		end
		if (over)
			q = NEG_LIM + 1;
		res.mag = q;
		res.neg = n.neg && q != 0;
		return clip(res);
	endfunction

	function automatic bit [63:0] int_sqrt(bit [63:0] s);
		bit [63:0] root;
		bit [63:0] b;
		root = 0;
		b = 64'd1 << 62;
		while (b > s)
			b = b >> 2;
		while (b != 0) begin
			if (s >= root + b) begin
				s = s - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic cplx_res_t compute(logic [3:0] cmd, logic [127:0] ops, logic [16:0] tol);
		longint    ar, ai, br, bi, re, im;
		bit [63:0] den;
		cplx_res_t r;
		ar = longint'($signed(ops[31:0]));
		ai = longint'($signed(ops[63:32]));
		br = longint'($signed(ops[95:64]));
		bi = longint'($signed(ops[127:96]));
		re = 0;
		im = 0;
		r.eq = 0;
		r.st = ST_OK;
		clipped = 0;
		case (cmd)
			CMD_ADD: begin
				re = clip(sm_of(ar + br));
				im = clip(sm_of(ai + bi));
			end
			CMD_SUB: begin
				re = clip(sm_of(ar - br));
				im = clip(sm_of(ai - bi));
			end
			CMD_MUL: begin
				re = drop_frac(sm_add(sm_mul(ar, br), sm_neg(sm_mul(ai, bi))));
				im = drop_frac(sm_add(sm_mul(ai, br), sm_mul(ar, bi)));
			end
			CMD_DIV: begin
				den = abs64(br) * abs64(br) + abs64(bi) * abs64(bi);
				if (den == 0) begin
					r.st = ST_DIV0;
				end else begin
					re = frac_div(sm_add(sm_mul(ar, br), sm_mul(ai, bi)), den);
					im = frac_div(sm_add(sm_mul(ai, br), sm_neg(sm_mul(ar, bi))), den);
				end
			end
			CMD_CONJ: begin
				re = ar;
				im = clip(sm_of(-ai));
			end
			CMD_NEG: begin
				re = clip(sm_of(-ar));
				im = clip(sm_of(-ai));
			end
			CMD_MAG: begin
				re = clip(sm_of(longint'(int_sqrt(sm_add(sm_mul(ar, ar), sm_mul(ai, ai)).mag))));
			end
			CMD_MAGSQ: begin
				re = drop_frac(sm_add(sm_mul(ar, ar), sm_mul(ai, ai)));
			end
			CMD_EQ: begin
				r.eq = abs64(ar - br) < 64'(tol) && abs64(ai - bi) < 64'(tol);
			end
			default: ;
		endcase
		if (r.st == ST_OK && clipped)
			r.st = ST_SAT;
		r.re = re[31:0];
		r.im = im[31:0];
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		cplx_res_t want;
		cplx_res_t got;
		if (!arst_n) begin
			tolerance = TOL_RESET;
			expected_results.delete();
			errors = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.re = m_axis_tdata[31:0];
				got.im = m_axis_tdata[63:32];
				got.eq = m_axis_tuser[0];
				got.st = m_axis_tuser[2:1];
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transfer re=%h im=%h eq=%b st=%0d",
						$time, got.re, got.im, got.eq, got.st);
				end else begin
					want = expected_results.pop_front();
					if (want.re !== got.re) begin
						errors++;
						$display("%0t: res_re expected %h actual %h", $time, want.re, got.re);
					end
					if (want.im !== got.im) begin
						errors++;
						$display("%0t: res_im expected %h actual %h", $time, want.im, got.im);
					end
					if (want.eq !== got.eq) begin
						errors++;
						$display("%0t: is_equal expected %b actual %b", $time, want.eq, got.eq);
					end
					if (want.st !== got.st) begin
						errors++;
						$display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(compute(s_axis_tuser, s_axis_tdata, tolerance));
			if (cfg_valid && cfg_ready)
				tolerance = cfg_data;
		end
	end

endmodule

FILE: tb/sv/tb_complex_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for complex_arithmetic_unit_top: directed and random operand transfers
// under varying stall patterns and tolerances. Uses cau_pkg and cau_scoreboard.
module tb_complex_arithmetic_unit_top;
	import cau_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN = 60;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic [3:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;
	logic [2:0]   m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [16:0]  cfg_data;
	int           errors;
	int           pending;
	int           quiet;
	int           send_idle;
	int           recv_idle;
	logic [16:0]  cur_tol;

	complex_arithmetic_unit_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	cau_scoreboard chk (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// tready only moves at rising edges, so its value at a falling edge holds for the next one
	task automatic send_op(logic [3:0] cmd, logic [31:0] ar, logic [31:0] ai,
			logic [31:0] br, logic [31:0] bi);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid = 0;
			@(negedge clk);
		end
		s_axis_tvalid = 1;
		s_axis_tuser = cmd;
		s_axis_tdata = {bi, br, ai, ar};
		while (!s_axis_tready)
			@(negedge clk);
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	task automatic write_tol(logic [16:0] v);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
		cfg_valid = 1;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 0;
		cur_tol = v;
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
			2: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
			3: begin
				case ($urandom_range(4))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0;
					3: return 32'hFFFF_FFFF;
					default: return 32'h0001_0000;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] near(logic [31:0] v);
		int span;
		span = int'(cur_tol) + 2;
		return v + 32'($urandom_range(0, 2 * span) - span);
	endfunction

	task automatic random_op();
		logic [3:0]  cmd;
		logic [31:0] ar, ai, br, bi;
		cmd = ($urandom_range(19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
		ar = pick_operand();
		ai = pick_operand();
		br = pick_operand();
		bi = pick_operand();
		if (cmd == CMD_EQ && $urandom_range(3) != 0) begin
			br = near(ar);
			bi = near(ai);
		end
		if (cmd == CMD_DIV && $urandom_range(9) == 0) begin
			br = 0;
			bi = ($urandom_range(1)) ? 32'h0 : 32'h1;
		end
		send_op(cmd, ar, ai, br, bi);
	endtask

	initial begin
		logic [16:0] tol_sets[3][2];
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = 0;
		m_axis_tready = 0;
		cfg_valid = 0;
		cfg_data = 0;
		quiet = 0;
		send_idle = 35;
		recv_idle = 49;
		cur_tol = TOL_RESET;
		tol_sets = '{'{17'd0, 17'd65536}, '{17'h1FFFF, 17'($urandom_range(1, 4000))},
			'{17'd1, TOL_RESET}};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_op(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
		send_op(CMD_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_0001);
		send_op(CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
		send_op(CMD_SUB, 32'h0003_0000, 32'h0, 32'h0001_0000, 32'h0);
		send_op(CMD_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000);
		send_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_op(CMD_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
		send_op(CMD_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
		send_op(CMD_DIV, 32'h0004_0000, 32'hFFFE_0000, 32'h0002_0000, 32'h0);
		send_op(CMD_DIV, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
		send_op(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_op(CMD_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
		send_op(CMD_CONJ, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
		send_op(CMD_NEG, 32'h8000_0000, 32'h0000_0001, 32'h0, 32'h0);
		send_op(CMD_NEG, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_op(CMD_MAG, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
		send_op(CMD_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
		send_op(CMD_MAGSQ, 32'h0002_0000, 32'hFFFF_0000, 32'h0, 32'h0);
		send_op(CMD_MAGSQ, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
		send_op(CMD_EQ, 32'h0001_0000, 32'h0, 32'h0001_0006, 32'hFFFF_FFFA);
		send_op(CMD_EQ, 32'h0001_0000, 32'h0, 32'h0001_0007, 32'h0);
		send_op(CMD_EQ, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
		send_op(4'd9, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_op(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 35 : (ph == 1) ? 49 : 0;
			recv_idle = (ph == 0) ? 49 : (ph == 1) ? 35 : 0;
			for (int t = 0; t < 2; t++) begin
				write_tol(tol_sets[ph][t]);
				for (int i = 0; i < 280; i++)
					random_op();
			end
		end

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
